@@ rtl/postfix_expression_evaluator_macros.svh @@
// Assertion macros used by the evaluator RTL.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_MACROS_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define PEE_ASSERT_IMPL(label, ck, rstn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("postfix evaluator: assertion failed");

// Next-cycle implication, checked out of reset.
`define PEE_ASSERT_NEXT(label, ck, rstn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("postfix evaluator: assertion failed");

`else

`define PEE_ASSERT_IMPL(label, ck, rstn, ante, cons)

`define PEE_ASSERT_NEXT(label, ck, rstn, ante, cons)

`endif

`endif

@@ rtl/pee_pkg.sv @@
`timescale 1ns / 1ps

package pee_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int LIM_W       = (CNT_W > 8) ? CNT_W : 8;
    localparam int PADDR_W     = 3;

    localparam logic       REG_IDX_STACK_LIMIT = 1'b0;
    localparam logic [7:0] STACK_LIMIT_RESET   = 8'd128;

    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_POW  = 8'h5E;
    localparam logic [7:0] CH_MUL  = 8'h2A;
    localparam logic [7:0] CH_DIV  = 8'h2F;
    localparam logic [7:0] CH_ADD  = 8'h2B;
    localparam logic [7:0] CH_SUB  = 8'h2D;
    localparam logic [7:0] CH_MOD  = 8'h25;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_DIVZERO   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        OP_POW = 3'd0,
        OP_MUL = 3'd1,
        OP_DIV = 3'd2,
        OP_ADD = 3'd3,
        OP_SUB = 3'd4,
        OP_MOD = 3'd5
    } op_t;

    typedef struct packed {
        logic        start;
        op_t         op;
        logic [31:0] lhs;
        logic [31:0] rhs;
    } alu_req_t;

    typedef struct packed {
        logic        done;
        logic        div_zero;
        logic [31:0] result;
    } alu_rsp_t;

    function automatic logic is_operand(input logic [7:0] c);
        return c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39]};
    endfunction

    function automatic logic is_operator(input logic [7:0] c);
        return c inside {CH_POW, CH_MUL, CH_DIV, CH_ADD, CH_SUB, CH_MOD};
    endfunction

    function automatic op_t op_of(input logic [7:0] c);
        op_t o;
        case (c)
            CH_POW:  o = OP_POW;
            CH_MUL:  o = OP_MUL;
            CH_DIV:  o = OP_DIV;
            CH_SUB:  o = OP_SUB;
            CH_MOD:  o = OP_MOD;
            default: o = OP_ADD;
        endcase
        return o;
    endfunction

    // Keep the highest-priority error; lower code wins once any is set.
    function automatic status_t merge_status(input status_t cur, input status_t code);
        return (cur == ST_OK || code < cur) ? code : cur;
    endfunction

endpackage

@@ rtl/pee_in_if.sv @@
`timescale 1ns / 1ps

interface pee_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       last;

    modport source (output valid, output symbol, output last, input ready);
    modport sink (input valid, input symbol, input last, output ready);
endinterface

@@ rtl/pee_out_if.sv @@
`timescale 1ns / 1ps

interface pee_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic [1:0]         status;

    modport source (output valid, output value, output status, input ready);
    modport sink (input valid, input value, input status, output ready);
endinterface

@@ rtl/postfix_expression_evaluator.sv @@
`timescale 1ns / 1ps

// Postfix (RPN) evaluator: one ASCII symbol per transaction on the symbols channel; a letter or
// digit pushes its code minus '0', an operator (^ * / + - %) pops right then left operand and
// pushes the 32-bit result, other bytes are ignored. The transaction marked last returns the
// stack top and a sticky status (0 ok, 1 overflow, 2 underflow, 3 divide by zero) on the
// results channel, then empties the stack. The stack lives in a single-port-read RAM of
// STACK_DEPTH words, so an item is handled one at a time: an operand is decoded and pushed, an
// ignored byte only decoded, + - * take two serial pops, an ALU operation and a push, / and % go
// through the bit-serial divider (skipped for a zero divisor), ^ squares and multiplies up to the
// exponent's highest set bit (skipped for a negative exponent), and a last symbol adds the final
// pop and waits while an earlier result still sits in the output register. A result may wait in
// the output register while the next symbols are taken. No clearing pass follows reset.
// stack_limit sits at byte address 0.
module postfix_expression_evaluator
    import pee_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    pee_in_if.sink             symbols,
    pee_out_if.source          results,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

`include "postfix_expression_evaluator_macros.svh"

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECODE = 7'b0000010,
        S_POP_L  = 7'b0000100,
        S_EXEC   = 7'b0001000,
        S_WAIT   = 7'b0010000,
        S_FINAL  = 7'b0100000,
        S_EMIT   = 7'b1000000
    } state_t;

    state_t             state_reg, state_next;
    logic [7:0]         sym_reg, sym_next;
    logic               last_reg, last_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    status_t            err_reg, err_next;
    logic [7:0]         limit_reg;
    logic [31:0]        rhs_reg, rhs_next;
    logic               under_reg, under_next;
    logic               out_valid_reg, out_valid_next;
    logic [31:0]        out_value_reg, out_value_next;
    status_t            out_status_reg, out_status_next;

    logic [LIM_W-1:0]   lim_ext;
    logic [LIM_W-1:0]   lim_eff;
    logic               full;
    logic               empty;
    logic [CNT_W-1:0]   cnt_dec;
    logic               push_go;
    logic               pop_go;
    logic               emit_go;
    logic [31:0]        push_val;
    logic [31:0]        operand_val;
    logic               cfg_we;

    logic               ram_we;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [31:0]        ram_rdata;

    alu_req_t           alu_req;
    alu_rsp_t           alu_rsp;

    assign lim_ext     = LIM_W'(limit_reg);
    assign lim_eff     = (lim_ext > LIM_W'(STACK_DEPTH)) ? LIM_W'(STACK_DEPTH) : lim_ext;
    assign full        = LIM_W'(count_reg) >= lim_eff;
    assign empty       = (count_reg == '0);
    assign cnt_dec     = count_reg - CNT_W'(1);
    assign ram_waddr   = count_reg[ADDR_W-1:0];
    assign ram_raddr   = cnt_dec[ADDR_W-1:0];
    assign operand_val = {24'd0, sym_reg} - {24'd0, CH_ZERO};
    assign push_val    = (state_reg == S_WAIT) ? alu_rsp.result : operand_val;

    assign symbols.ready = (state_reg == S_IDLE);

    always_comb
    begin
        status_t err_v;

        state_next      = state_reg;
        sym_next        = sym_reg;
        last_next       = last_reg;
        count_next      = count_reg;
        rhs_next        = rhs_reg;
        under_next      = under_reg;
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        push_go         = 1'b0;
        pop_go          = 1'b0;
        emit_go         = 1'b0;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        alu_req         = '0;
        err_v           = err_reg;

        if (out_valid_reg && results.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (symbols.valid)
                begin
                    sym_next   = symbols.symbol;
                    last_next  = symbols.last;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (is_operand(sym_reg))
                begin
                    push_go    = 1'b1;
                    state_next = last_reg ? S_FINAL : S_IDLE;
                end
                else if (is_operator(sym_reg))
                begin
                    pop_go     = 1'b1;
                    state_next = S_POP_L;
                end
                else
                begin
                    state_next = last_reg ? S_FINAL : S_IDLE;
                end
            end
            S_POP_L:
            begin
                rhs_next   = under_reg ? 32'd0 : ram_rdata;
                pop_go     = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                alu_req.start = 1'b1;
                alu_req.op    = op_of(sym_reg);
                alu_req.lhs   = under_reg ? 32'd0 : ram_rdata;
                alu_req.rhs   = rhs_reg;
                state_next    = S_WAIT;
            end
            S_WAIT:
            begin
                if (alu_rsp.done)
                begin
                    if (alu_rsp.div_zero)
                    begin
                        err_v = merge_status(err_v, ST_DIVZERO);
                    end
                    push_go    = 1'b1;
                    state_next = last_reg ? S_FINAL : S_IDLE;
                end
            end
            S_FINAL:
            begin
                pop_go     = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    emit_go         = 1'b1;
                    out_valid_next  = 1'b1;
                    out_value_next  = under_reg ? 32'd0 : ram_rdata;
                    out_status_next = err_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (pop_go)
        begin
            if (empty)
            begin
                under_next = 1'b1;
                err_v      = merge_status(err_v, ST_UNDERFLOW);
            end
            else
            begin
                under_next = 1'b0;
                count_next = cnt_dec;
                ram_re     = 1'b1;
            end
        end

        if (push_go)
        begin
            if (full)
            begin
                err_v = merge_status(err_v, ST_OVERFLOW);
            end
            else
            begin
                ram_we     = 1'b1;
                count_next = count_reg + CNT_W'(1);
            end
        end

        // Drop the stack and status once the result is taken into the output register.
        if (emit_go)
        begin
            count_next = '0;
            err_next   = ST_OK;
        end
        else
        begin
            err_next = err_v;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            err_reg       <= ST_OK;
            limit_reg     <= STACK_LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                limit_reg <= pwdata[7:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg        <= sym_next;
        last_reg       <= last_next;
        rhs_reg        <= rhs_next;
        under_reg      <= under_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    assign cfg_we = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_IDX_STACK_LIMIT);
    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_W-1] == REG_IDX_STACK_LIMIT) ? {24'd0, limit_reg} : 32'd0;

    assign results.valid  = out_valid_reg;
    assign results.value  = out_value_reg;
    assign results.status = out_status_reg;

    pee_ram #(
        .WIDTH (32),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (push_val),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pee_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    `PEE_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(STACK_DEPTH))
    `PEE_ASSERT_IMPL(a_push_room, clk, rst_n, ram_we, LIM_W'(count_reg) < lim_eff)
    `PEE_ASSERT_NEXT(a_emit_clears, clk, rst_n, emit_go, count_reg == '0 && err_reg == ST_OK && out_valid_reg)
    `PEE_ASSERT_IMPL(a_alu_done_wait, clk, rst_n, alu_rsp.done, state_reg == S_WAIT)

endmodule

@@ rtl/pee_ram.sv @@
`timescale 1ns / 1ps

module pee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/pee_alu.sv @@
`timescale 1ns / 1ps

module pee_alu
    import pee_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    typedef enum logic [4:0] {
        A_IDLE = 5'b00001,
        A_DIV  = 5'b00010,
        A_FIX  = 5'b00100,
        A_POW  = 5'b01000,
        A_DONE = 5'b10000
    } alu_state_t;

    alu_state_t  state_reg, state_next;
    op_t         op_reg, op_next;
    logic        neg_l_reg, neg_l_next;
    logic        neg_r_reg, neg_r_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] dsr_reg, dsr_next;
    logic [4:0]  step_reg, step_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] base_reg, base_next;
    logic [31:0] exp_reg, exp_next;
    logic [31:0] res_reg, res_next;
    logic        dz_reg, dz_next;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] mul_p;
    logic [31:0] sq_p;
    logic [32:0] trial;

    function automatic logic [31:0] magnitude(input logic [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

    assign mul_a = (state_reg == A_IDLE) ? req.lhs : acc_reg;
    assign mul_b = (state_reg == A_IDLE) ? req.rhs : base_reg;
    assign mul_p = mul_a * mul_b;
    assign sq_p  = base_reg * base_reg;
    assign trial = {rem_reg, quo_reg[31]} - {1'b0, dsr_reg};

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        neg_l_next = neg_l_reg;
        neg_r_next = neg_r_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dsr_next   = dsr_reg;
        step_next  = step_reg;
        acc_next   = acc_reg;
        base_next  = base_reg;
        exp_next   = exp_reg;
        res_next   = res_reg;
        dz_next    = dz_reg;

        case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    op_next    = req.op;
                    dz_next    = 1'b0;
                    neg_l_next = req.lhs[31];
                    neg_r_next = req.rhs[31];
                    case (req.op)
                        OP_ADD:
                        begin
                            res_next   = req.lhs + req.rhs;
                            state_next = A_DONE;
                        end
                        OP_SUB:
                        begin
                            res_next   = req.lhs - req.rhs;
                            state_next = A_DONE;
                        end
                        OP_MUL:
                        begin
                            res_next   = mul_p;
                            state_next = A_DONE;
                        end
                        OP_DIV, OP_MOD:
                        begin
                            if (req.rhs == 32'd0)
                            begin
                                res_next   = 32'd0;
                                dz_next    = 1'b1;
                                state_next = A_DONE;
                            end
                            else
                            begin
                                quo_next   = magnitude(req.lhs);
                                dsr_next   = magnitude(req.rhs);
                                rem_next   = 32'd0;
                                step_next  = 5'd31;
                                state_next = A_DIV;
                            end
                        end
                        OP_POW:
                        begin
                            if (req.rhs[31])
                            begin
                                if (req.lhs == 32'd1)
                                begin
                                    res_next = 32'd1;
                                end
                                else if (req.lhs == 32'hFFFF_FFFF)
                                begin
                                    res_next = req.rhs[0] ? 32'hFFFF_FFFF : 32'd1;
                                end
                                else
                                begin
                                    res_next = 32'd0;
                                end
                                state_next = A_DONE;
                            end
                            else
                            begin
                                acc_next   = 32'd1;
                                base_next  = req.lhs;
                                exp_next   = req.rhs;
                                state_next = A_POW;
                            end
                        end
                        default:
                        begin
                            res_next   = 32'd0;
                            state_next = A_DONE;
                        end
                    endcase
                end
            end
            A_DIV:
            begin
                if (!trial[32])
                begin
                    rem_next = trial[31:0];
                end
                else
                begin
                    rem_next = {rem_reg[30:0], quo_reg[31]};
                end
                quo_next  = {quo_reg[30:0], ~trial[32]};
                step_next = step_reg - 5'd1;
                if (step_reg == 5'd0)
                begin
                    state_next = A_FIX;
                end
            end
            A_FIX:
            begin
                if (op_reg == OP_DIV)
                begin
                    res_next = (neg_l_reg ^ neg_r_reg) ? (32'd0 - quo_reg) : quo_reg;
                end
                else
                begin
                    res_next = neg_l_reg ? (32'd0 - rem_reg) : rem_reg;
                end
                state_next = A_DONE;
            end
            A_POW:
            begin
                if (exp_reg == 32'd0)
                begin
                    res_next   = acc_reg;
                    state_next = A_DONE;
                end
                else
                begin
                    if (exp_reg[0])
                    begin
                        acc_next = mul_p;
                    end
                    base_next = sq_p;
                    exp_next  = {1'b0, exp_reg[31:1]};
                end
            end
            A_DONE:
            begin
                state_next = A_IDLE;
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        neg_l_reg <= neg_l_next;
        neg_r_reg <= neg_r_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        dsr_reg   <= dsr_next;
        step_reg  <= step_next;
        acc_reg   <= acc_next;
        base_reg  <= base_next;
        exp_reg   <= exp_next;
        res_reg   <= res_next;
        dz_reg    <= dz_next;
    end

    assign rsp.done     = (state_reg == A_DONE);
    assign rsp.div_zero = dz_reg;
    assign rsp.result   = res_reg;

endmodule
